// File: hw/rtl/ptc_pkg.sv
// Shared types and constants for the pressure and temperature compensation pipeline.
package ptc_pkg;

	localparam int NSTAGE = 8;
	localparam int TEMP_STAGES = 4;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] REG_PRESSURE_SENSITIVITY = 3'd0;
	localparam logic [CFG_IW-1:0] REG_PRESSURE_OFFSET = 3'd1;
	localparam logic [CFG_IW-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
	localparam logic [CFG_IW-1:0] REG_OFFSET_TEMP_COEFF = 3'd3;
	localparam logic [CFG_IW-1:0] REG_REFERENCE_TEMPERATURE = 3'd4;
	localparam logic [CFG_IW-1:0] REG_TEMPERATURE_COEFF = 3'd5;

	localparam logic signed [19:0] TEMP_MID = 20'sd2000;
	localparam logic signed [19:0] TEMP_LOW_OFS = 20'sd3500;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} in_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic signed [31:0] pressure_deci;
	} out_t;

	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sensitivity_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] reference_temperature;
		logic [15:0] temperature_coeff;
	} cfg_t;

	typedef struct packed {
		logic signed [41:0] off;
		logic signed [41:0] sens;
		logic [31:0] temp;
		logic [23:0] d1;
	} mid_t;

endpackage

// File: hw/rtl/ptc_cfg.sv
// Calibration word registers written through the configuration port.
module ptc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [ptc_pkg::CFG_IW-1:0]   wr_index,
	input  logic [ptc_pkg::CFG_DW-1:0]   wr_data,
	output ptc_pkg::cfg_t                cfg
);

	ptc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				ptc_pkg::REG_PRESSURE_SENSITIVITY: begin
					cfg_q.pressure_sensitivity <= wr_data;
				end
				ptc_pkg::REG_PRESSURE_OFFSET: begin
					cfg_q.pressure_offset <= wr_data;
				end
				ptc_pkg::REG_SENSITIVITY_TEMP_COEFF: begin
					cfg_q.sensitivity_temp_coeff <= wr_data;
				end
				ptc_pkg::REG_OFFSET_TEMP_COEFF: begin
					cfg_q.offset_temp_coeff <= wr_data;
				end
				ptc_pkg::REG_REFERENCE_TEMPERATURE: begin
					cfg_q.reference_temperature <= wr_data;
				end
				ptc_pkg::REG_TEMPERATURE_COEFF: begin
					cfg_q.temperature_coeff <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/ptc_ctl.sv
// Valid bits and per-stage load enables of the compensation pipeline.
module ptc_ctl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          raw_valid,
	input  logic                          comp_stall,
	output logic [ptc_pkg::NSTAGE-1:0]    en,
	output logic [ptc_pkg::NSTAGE-1:0]    vld
);

	logic [ptc_pkg::NSTAGE-1:0] vld_q;

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		en[ptc_pkg::NSTAGE-1] = !vld_q[ptc_pkg::NSTAGE-1] || !comp_stall;
		for (int i = ptc_pkg::NSTAGE-2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= raw_valid;
			end
			for (int i = 1; i < ptc_pkg::NSTAGE; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign vld = vld_q;

endmodule

// File: hw/rtl/ptc_temp.sv
// Stages one to four: temperature difference, first and second order temperature, offset and sensitivity.
module ptc_temp (
	input  logic                              clk,
	input  logic [ptc_pkg::TEMP_STAGES-1:0]   en,
	input  ptc_pkg::cfg_t                     cfg,
	input  ptc_pkg::in_t                      raw,
	output ptc_pkg::mid_t                     mid
);

	logic signed [24:0] dt_s1;
	logic [23:0]        d1_s1;

	logic [24:0]        dt_mag;
	logic signed [41:0] dtc6_s2;
	logic [49:0]        dtsq_s2;
	logic signed [41:0] c4dt_s2;
	logic signed [41:0] c3dt_s2;
	logic [23:0]        d1_s2;

	logic signed [18:0] dev;
	logic signed [19:0] low;
	logic signed [37:0] dev_sq;
	logic signed [39:0] low_sq;
	logic [52:0]        dtsq7;
	logic [18:0]        t2;
	logic [36:0]        dev_sq_s3;
	logic [37:0]        low_sq_s3;
	logic               neg_s3;
	logic               below_s3;
	logic [18:0]        t2_s3;
	logic signed [19:0] temp_s3;
	logic signed [41:0] off_base_s3;
	logic signed [41:0] sens_base_s3;
	logic [23:0]        d1_s3;

	logic [41:0]        dsq;
	logic [41:0]        lsq;
	logic [41:0]        off2;
	logic [41:0]        sens2;
	ptc_pkg::mid_t      mid_s4;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dt_s1 <= $signed({1'b0, raw.raw_temperature})
				- $signed({1'b0, cfg.reference_temperature, 8'b0});
			d1_s1 <= raw.raw_pressure;
		end
	end

	always_comb begin
		dt_mag = dt_s1[24] ? 25'(-dt_s1) : 25'(dt_s1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dtc6_s2 <= dt_s1 * $signed({1'b0, cfg.temperature_coeff});
			dtsq_s2 <= dt_mag * dt_mag;
			c4dt_s2 <= dt_s1 * $signed({1'b0, cfg.offset_temp_coeff});
			c3dt_s2 <= dt_s1 * $signed({1'b0, cfg.sensitivity_temp_coeff});
			d1_s2   <= d1_s1;
		end
	end

	always_comb begin
		dev    = dtc6_s2[41:23];
		low    = {dev[18], dev} + ptc_pkg::TEMP_LOW_OFS;
		dev_sq = dev * dev;
		low_sq = low * low;
		dtsq7  = {3'b0, dtsq_s2} * 53'd7;
		if (dev[18]) begin
			t2 = {2'b0, dtsq_s2[49:33]} * 19'd3;
		end else begin
			t2 = {3'b0, dtsq7[52:37]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dev_sq_s3    <= dev_sq[36:0];
			low_sq_s3    <= low_sq[37:0];
			neg_s3       <= dev[18];
			below_s3     <= low[19];
			t2_s3        <= t2;
			temp_s3      <= {dev[18], dev} + ptc_pkg::TEMP_MID;
			off_base_s3  <= {10'b0, cfg.pressure_offset, 16'b0}
				+ {{7{c4dt_s2[41]}}, c4dt_s2[41:7]};
			sens_base_s3 <= {11'b0, cfg.pressure_sensitivity, 15'b0}
				+ {{8{c3dt_s2[41]}}, c3dt_s2[41:8]};
			d1_s3        <= d1_s2;
		end
	end

	always_comb begin
		dsq = {5'b0, dev_sq_s3};
		lsq = {4'b0, low_sq_s3};
		if (neg_s3) begin
			off2  = ((dsq * 42'd3) >> 1) + (below_s3 ? lsq * 42'd7 : 42'd0);
			sens2 = ((dsq * 42'd5) >> 3) + (below_s3 ? lsq << 2 : 42'd0);
		end else begin
			off2  = dsq >> 4;
			sens2 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			mid_s4.off  <= off_base_s3 - off2;
			mid_s4.sens <= sens_base_s3 - sens2;
			mid_s4.temp <= {{12{temp_s3[19]}}, temp_s3} - {13'b0, t2_s3};
			mid_s4.d1   <= d1_s3;
		end
	end

	assign mid = mid_s4;

endmodule

// File: hw/rtl/ptc_press.sv
// Stages five to eight: sensitivity product split in two halves and the truncating scale-down of pressure.
module ptc_press (
	input  logic                                              clk,
	input  logic [ptc_pkg::NSTAGE-ptc_pkg::TEMP_STAGES-1:0]   en,
	input  ptc_pkg::mid_t                                     mid,
	output ptc_pkg::out_t                                     comp
);

	logic [44:0]        plo_s5;
	logic signed [45:0] phi_s5;
	logic               neg_s5;
	logic signed [41:0] off_s5;
	logic [31:0]        temp_s5;

	logic [66:0]        sum;
	logic signed [45:0] q1_s6;
	logic signed [41:0] off_s6;
	logic [31:0]        temp_s6;

	logic signed [45:0] diff_s7;
	logic [31:0]        temp_s7;

	logic [45:0]        adj;
	ptc_pkg::out_t      comp_s8;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			plo_s5  <= mid.sens[20:0] * mid.d1;
			phi_s5  <= $signed(mid.sens[41:21]) * $signed({1'b0, mid.d1});
			neg_s5  <= mid.sens[41];
			off_s5  <= mid.off;
			temp_s5 <= mid.temp;
		end
	end

	// A negative product is biased before the shift so that it truncates toward zero.
	always_comb begin
		sum = {phi_s5, 21'b0} + {22'b0, plo_s5}
			+ (neg_s5 ? {46'b0, {21{1'b1}}} : 67'b0);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q1_s6   <= sum[66:21];
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			diff_s7 <= q1_s6 - {{4{off_s6[41]}}, off_s6};
			temp_s7 <= temp_s6;
		end
	end

	always_comb begin
		adj = diff_s7 + (diff_s7[45] ? 46'd32767 : 46'd0);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			comp_s8.temperature_centi <= temp_s7;
			comp_s8.pressure_deci     <= {adj[45], adj[45:15]};
		end
	end

	assign comp = comp_s8;

endmodule

// File: hw/rtl/pressure_temperature_compensation.sv
// Top level of the pressure and temperature compensation pipeline.
//
//  channel   direction  handshake                payload
//  raw       in         raw_valid / raw_stall    ptc_pkg::in_t  (D1, D2)
//  comp      out        comp_valid / comp_stall  ptc_pkg::out_t (temperature, pressure)
//  wr        in         wr_en                    wr_index, wr_data (calibration words)
//
// Each transaction passes through eight register stages; one transaction can
// enter every cycle while raw_stall is low.
// The depth is set by the multiplier stages in the temperature path and
// the split 42 by 24 bit sensitivity product in the pressure path.
// Reset clears the calibration words and all valid bits.
// A stall holds the output; empty stages still fill, so raw_stall rises only
// when every stage holds a transaction.
module pressure_temperature_compensation (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         raw_valid,
	output logic                         raw_stall,
	input  ptc_pkg::in_t                 raw,
	output logic                         comp_valid,
	input  logic                         comp_stall,
	output ptc_pkg::out_t                comp,
	input  logic                         wr_en,
	input  logic [ptc_pkg::CFG_IW-1:0]   wr_index,
	input  logic [ptc_pkg::CFG_DW-1:0]   wr_data
);

	ptc_pkg::cfg_t               cfg;
	ptc_pkg::mid_t               mid;
	logic [ptc_pkg::NSTAGE-1:0]  en;
	logic [ptc_pkg::NSTAGE-1:0]  vld;

	ptc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	ptc_ctl u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw_valid  (raw_valid),
		.comp_stall (comp_stall),
		.en         (en),
		.vld        (vld)
	);

	ptc_temp u_temp (
		.clk (clk),
		.en  (en[ptc_pkg::TEMP_STAGES-1:0]),
		.cfg (cfg),
		.raw (raw),
		.mid (mid)
	);

	ptc_press u_press (
		.clk  (clk),
		.en   (en[ptc_pkg::NSTAGE-1:ptc_pkg::TEMP_STAGES]),
		.mid  (mid),
		.comp (comp)
	);

	assign raw_stall  = !en[0];
	assign comp_valid = vld[ptc_pkg::NSTAGE-1];

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		raw_stall |-> ($countones(vld) == ptc_pkg::NSTAGE) && comp_stall)
		else $error("input stalled while the pipeline has room");

	a_full_and_blocked_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(($countones(vld) == ptc_pkg::NSTAGE) && comp_stall) |-> raw_stall)
		else $error("input accepted into a full, blocked pipeline");

	a_accept_enters_first: assert property (@(posedge clk) disable iff (!arst_n)
		(raw_valid && !raw_stall) |=> vld[0])
		else $error("accepted transaction lost at the first stage");

	a_output_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(comp_valid && !comp_stall) |=> (comp_valid == $past(vld[ptc_pkg::NSTAGE-2])))
		else $error("output valid does not follow the stage before it");

endmodule

// File: tb/tb_pressure_temperature_compensation.sv
// Self-checking testbench for the pressure and temperature compensation pipeline.
module tb_pressure_temperature_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ptc_pkg::CFG_IW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [ptc_pkg::CFG_IW-1:0] REG_SPARE_B = 3'd7;
	localparam longint MID_TEMP = 2000;
	localparam longint LOW_TEMP = -1500;
	localparam longint RAW_MAX = 64'sd16777215;
	localparam logic [23:0] TYPICAL_D1 = 24'd9085466;
	localparam int HOLD_CYCLES = 64;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic raw_valid = 1'b0;
	logic raw_stall;
	ptc_pkg::in_t raw = '0;
	logic comp_valid;
	logic comp_stall = 1'b0;
	ptc_pkg::out_t comp;
	logic wr_en = 1'b0;
	logic [ptc_pkg::CFG_IW-1:0] wr_index = '0;
	logic [ptc_pkg::CFG_DW-1:0] wr_data = '0;

	ptc_pkg::cfg_t cal = '0;
	ptc_pkg::in_t reading_q[$];
	ptc_pkg::out_t compensated_q[$];
	ptc_pkg::out_t comp_want;
	bit reading_taken = 1'b0;
	bit hold_request = 1'b0;
	logic hold_off = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int failures = 0;
	int cycle_count = 0;

	pressure_temperature_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.raw_valid(raw_valid),
		.raw_stall(raw_stall),
		.raw(raw),
		.comp_valid(comp_valid),
		.comp_stall(comp_stall),
		.comp(comp),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic ptc_pkg::out_t compensate(input ptc_pkg::in_t item,
			input ptc_pkg::cfg_t c);
		longint k1, k2, k3, k4, k5, k6;
		longint d1, d2, dt, dt_sq, temp, dev_sq, low_sq, t2, off2, sens2, off, sens;
		longint t_final, p_final;
		ptc_pkg::out_t r;
		k1 = c.pressure_sensitivity;
		k2 = c.pressure_offset;
		k3 = c.sensitivity_temp_coeff;
		k4 = c.offset_temp_coeff;
		k5 = c.reference_temperature;
		k6 = c.temperature_coeff;
		d1 = item.raw_pressure;
		d2 = item.raw_temperature;
		dt = d2 - k5 * 256;
		temp = ((dt * k6) >>> 23) + MID_TEMP;
		dt_sq = dt * dt;
		dev_sq = (temp - MID_TEMP) * (temp - MID_TEMP);
		if (temp < MID_TEMP) begin
			t2 = 3 * (dt_sq >>> 33);
			off2 = (3 * dev_sq) / 2;
			sens2 = (5 * dev_sq) / 8;
			if (temp < LOW_TEMP) begin
				low_sq = (temp - LOW_TEMP) * (temp - LOW_TEMP);
				off2 = off2 + 7 * low_sq;
				sens2 = sens2 + 4 * low_sq;
			end
		end else begin
			t2 = (7 * dt_sq) >>> 37;
			off2 = dev_sq / 16;
			sens2 = 0;
		end
		off = k2 * 65536 + ((k4 * dt) >>> 7) - off2;
		sens = k1 * 32768 + ((k3 * dt) >>> 8) - sens2;
		t_final = temp - t2;
		p_final = ((sens * d1) / 2097152 - off) / 32768;
		r.temperature_centi = t_final[31:0];
		r.pressure_deci = p_final[31:0];
		return r;
	endfunction

	function automatic logic [23:0] to_raw(input longint v);
		if (v < 0)
			return 24'd0;
		if (v > RAW_MAX)
			return 24'hFFFFFF;
		return v[23:0];
	endfunction

	// Smallest raw temperature whose first-order temperature reaches the target.
	function automatic logic [23:0] raw_for_temp(input longint target);
		longint num, k6, dt;
		k6 = cal.temperature_coeff;
		num = (target - MID_TEMP) * 64'sd8388608;
		dt = 0;
		if (k6 != 0) begin
			dt = num / k6;
			if (num > 0 && num % k6 != 0)
				dt = dt + 1;
		end
		return to_raw(longint'(cal.reference_temperature) * 256 + dt);
	endfunction

	function automatic ptc_pkg::in_t random_reading();
		ptc_pkg::in_t r;
		longint centre;
		r.raw_pressure = 24'($urandom_range(24'hFFFFFF));
		r.raw_temperature = 24'($urandom_range(24'hFFFFFF));
		case ($urandom_range(7))
			0: r.raw_pressure = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
			1: r.raw_temperature = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
			2, 3: begin
				centre = longint'(cal.reference_temperature) * 256;
				r.raw_temperature = to_raw(centre + longint'($urandom_range(131072)) - 65536);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic ptc_pkg::cfg_t random_calibration();
		ptc_pkg::cfg_t c;
		c.pressure_sensitivity = 16'($urandom_range(65535));
		c.pressure_offset = 16'($urandom_range(65535));
		c.sensitivity_temp_coeff = 16'($urandom_range(65535));
		c.offset_temp_coeff = 16'($urandom_range(65535));
		c.reference_temperature = 16'($urandom_range(65535));
		c.temperature_coeff = 16'($urandom_range(65535));
		return c;
	endfunction

	function automatic bit pipeline_busy();
		return reading_q.size() != 0 || raw_valid || compensated_q.size() != 0;
	endfunction

	task automatic apply_register(input logic [ptc_pkg::CFG_IW-1:0] idx,
			input logic [ptc_pkg::CFG_DW-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
			ptc_pkg::REG_PRESSURE_SENSITIVITY: cal.pressure_sensitivity = value;
			ptc_pkg::REG_PRESSURE_OFFSET: cal.pressure_offset = value;
			ptc_pkg::REG_SENSITIVITY_TEMP_COEFF: cal.sensitivity_temp_coeff = value;
			ptc_pkg::REG_OFFSET_TEMP_COEFF: cal.offset_temp_coeff = value;
			ptc_pkg::REG_REFERENCE_TEMPERATURE: cal.reference_temperature = value;
			ptc_pkg::REG_TEMPERATURE_COEFF: cal.temperature_coeff = value;
			default: ;
		endcase
	endtask

	task automatic run_phase(input ptc_pkg::cfg_t c, input int send_pct, input int recv_pct,
			input int n_items, input bit directed, input bit press);
		logic [23:0] d2;
		longint band_edge [4];
		band_edge = '{2000, -1500, -20000, 5000};
		while (pipeline_busy())
			@(posedge clk);
		apply_register(REG_SPARE_A, 16'($urandom_range(65535)));
		apply_register(ptc_pkg::REG_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
		apply_register(ptc_pkg::REG_PRESSURE_OFFSET, c.pressure_offset);
		apply_register(ptc_pkg::REG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
		apply_register(ptc_pkg::REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
		apply_register(ptc_pkg::REG_REFERENCE_TEMPERATURE, c.reference_temperature);
		apply_register(ptc_pkg::REG_TEMPERATURE_COEFF, c.temperature_coeff);
		apply_register(REG_SPARE_B, 16'($urandom_range(65535)));
		@(negedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (press)
			hold_request = 1'b1;
		if (directed) begin
			reading_q.push_back(ptc_pkg::in_t'{24'd0, 24'd0});
			reading_q.push_back(ptc_pkg::in_t'{24'hFFFFFF, 24'hFFFFFF});
			reading_q.push_back(ptc_pkg::in_t'{24'd0, 24'hFFFFFF});
			reading_q.push_back(ptc_pkg::in_t'{24'hFFFFFF, 24'd0});
			reading_q.push_back(ptc_pkg::in_t'{TYPICAL_D1, {cal.reference_temperature, 8'd0}});
			foreach (band_edge[i]) begin
				d2 = raw_for_temp(band_edge[i]);
				reading_q.push_back(ptc_pkg::in_t'{TYPICAL_D1, d2});
				reading_q.push_back(ptc_pkg::in_t'{24'hFFFFFF, d2 - 24'd1});
			end
		end
		repeat (n_items)
			reading_q.push_back(random_reading());
	endtask

	always @(negedge clk) begin
		if (!raw_valid || reading_taken) begin
			if (reading_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				raw <= reading_q.pop_front();
				raw_valid <= 1'b1;
			end else begin
				raw_valid <= 1'b0;
			end
		end
		comp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		reading_taken = arst_n && raw_valid && !raw_stall;
		if (reading_taken)
			compensated_q.push_back(compensate(raw, cal));
		if (arst_n && comp_valid && !comp_stall) begin
			if (compensated_q.size() == 0) begin
				$error("unexpected transaction: temperature_centi %0d pressure_deci %0d",
					comp.temperature_centi, comp.pressure_deci);
				failures++;
			end else begin
				comp_want = compensated_q.pop_front();
				if (comp.temperature_centi !== comp_want.temperature_centi) begin
					$error("temperature_centi: expected %0d, actual %0d",
						comp_want.temperature_centi, comp.temperature_centi);
					failures++;
				end
				if (comp.pressure_deci !== comp_want.pressure_deci) begin
					$error("pressure_deci: expected %0d, actual %0d",
						comp_want.pressure_deci, comp.pressure_deci);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The receiver holds off long enough for every stage to fill and the input to stall.
	initial begin
		wait (hold_request);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_phase('{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
			19, 82, 250, 1'b1, 1'b0);
		run_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			19, 82, 250, 1'b0, 1'b0);
		run_phase('0, 19, 82, 200, 1'b0, 1'b0);
		run_phase(random_calibration(), 82, 19, 250, 1'b0, 1'b0);
		run_phase('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF},
			82, 19, 250, 1'b0, 1'b0);
		run_phase(random_calibration(), 0, 0, 250, 1'b0, 1'b1);
		run_phase('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0},
			0, 0, 250, 1'b0, 1'b0);
		while (pipeline_busy())
			@(posedge clk);
		repeat (2 * ptc_pkg::NSTAGE)
			@(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
